// ----- design/ctt_pkg.sv -----
package ctt_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0] KIND_UNKNOWN = 4'd0;
  localparam logic [3:0] KIND_ENTITY  = 4'd1;
  localparam logic [3:0] KIND_NUMBER  = 4'd2;
  localparam logic [3:0] KIND_ASSIGN  = 4'd3;
  localparam logic [3:0] KIND_APPEND  = 4'd4;
  localparam logic [3:0] KIND_STRING  = 4'd5;
  localparam logic [3:0] KIND_LABEL   = 4'd6;
  localparam logic [3:0] KIND_TERM    = 4'd7;
  localparam logic [3:0] KIND_DELIM   = 4'd8;
  localparam logic [3:0] KIND_OPEN    = 4'd9;
  localparam logic [3:0] KIND_CLOSE   = 4'd10;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_ENTITY  = 8'b0000_0010,
    MODE_NUMBER  = 8'b0000_0100,
    MODE_STRING  = 8'b0000_1000,
    MODE_ESCAPE  = 8'b0001_0000,
    MODE_AFTER   = 8'b0010_0000,
    MODE_PLUS    = 8'b0100_0000,
    MODE_COMMENT = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic       is_token_end;
    logic [3:0] token_kind;
    logic [7:0] data_char;
    logic       stream_done;
    logic       last_of_item;
  } result_t;

endpackage

// ----- design/ctt_if.sv -----
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface ctt_out_if;
  logic       valid;
  logic       ready;
  logic       is_token_end;
  logic [3:0] token_kind;
  logic [7:0] data_char;
  logic       stream_done;
  logic       last_of_item;

  modport source (output valid, output is_token_end, output token_kind, output data_char,
                  output stream_done, output last_of_item, input ready);
  modport sink   (input valid, input is_token_end, input token_kind, input data_char,
                  input stream_done, input last_of_item, output ready);
endinterface

// ----- design/config_text_tokenizer.sv -----
// Configuration text tokenizer.
// in_chan carries one byte of text per request (char_in), or an end-of-text
// marker that closes any open token and returns the lexer to idle.
// out_chan carries the tokens: a run of data-character results followed by
// one token-end result with the kind; last_of_item marks the final result of
// a request and stream_done the final result of an end-of-text request.
// A request gives zero, one or two results.
// Each accepted byte is lexed in the cycle it is accepted and its results are
// written into a four-entry result queue, and out_chan shows the queue's head.
// With a receiver that is always ready the block takes one byte per cycle when
// each byte gives at most one result; the queue has a single result read
// port, so a byte that gives two results hands them out one at a time.
// in_chan.ready is high while the queue has room for two results, so a
// stalled receiver fills the queue and then holds off new requests; nothing is
// dropped. Reset empties the queue and puts the lexer in idle between tokens.
module config_text_tokenizer (
  input  logic clk,
  input  logic rst_n,
  ctt_in_if.sink    in_chan,
  ctt_out_if.source out_chan
);

  // The queue depth is a power of two so that the pointers wrap on their own.
  localparam int FifoDepth = ctt_pkg::FIFO_DEPTH;
  localparam int PtrW      = ctt_pkg::PTR_W;
  localparam int CntW      = ctt_pkg::CNT_W;

  ctt_pkg::mode_t mode_r, mode_nxt;
  logic           quote_single_r, quote_single_nxt;
  logic           dp_seen_r, dp_seen_nxt;

  ctt_pkg::result_t fifo_r [FifoDepth];
  logic [PtrW-1:0]  head_r, tail_r;
  logic [CntW-1:0]  count_r;

  ctt_pkg::result_t res0, res1;
  logic [1:0]       res_cnt;
  logic             accept, pop;
  logic [7:0]       c;
  logic             restart;

  function automatic logic is_space(input logic [7:0] ch);
    return ch == ctt_pkg::CH_SPACE || ch == ctt_pkg::CH_TAB ||
           ch == ctt_pkg::CH_CR || ch == ctt_pkg::CH_LF;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic ctt_pkg::result_t mk(input logic end_flag, input logic [3:0] kind,
                                          input logic [7:0] ch);
    ctt_pkg::result_t r;
    r.is_token_end = end_flag;
    r.token_kind   = kind;
    r.data_char    = end_flag ? 8'h00 : ch;
    r.stream_done  = 1'b0;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  assign c      = in_chan.char_in;
  assign accept = in_chan.valid && in_chan.ready;
  assign pop    = out_chan.valid && out_chan.ready;

  // The lexer step: a result from the open token comes first, and a result
  // from starting a new token on the same byte comes second.
  always_comb begin
    ctt_pkg::result_t slot_a, slot_b, nr;
    logic             has_a, has_b, has_n;
    slot_a  = mk(1'b0, ctt_pkg::KIND_UNKNOWN, 8'h00);
    slot_b  = slot_a;
    nr      = slot_a;
    has_a   = 1'b0;
    has_b   = 1'b0;
    has_n   = 1'b0;
    restart = 1'b0;
    mode_nxt         = mode_r;
    quote_single_nxt = quote_single_r;
    dp_seen_nxt      = dp_seen_r;

    if (in_chan.end_of_text) begin
      has_a = 1'b1;
      unique case (mode_r)
        ctt_pkg::MODE_ENTITY: slot_a = mk(1'b1, ctt_pkg::KIND_ENTITY, 8'h00);
        ctt_pkg::MODE_NUMBER: slot_a = mk(1'b1, ctt_pkg::KIND_NUMBER, 8'h00);
        ctt_pkg::MODE_STRING, ctt_pkg::MODE_ESCAPE, ctt_pkg::MODE_AFTER:
          slot_a = mk(1'b1, ctt_pkg::KIND_STRING, 8'h00);
        ctt_pkg::MODE_PLUS:   slot_a = mk(1'b1, ctt_pkg::KIND_UNKNOWN, 8'h00);
        default:              has_a  = 1'b0;
      endcase
      mode_nxt         = ctt_pkg::MODE_IDLE;
      quote_single_nxt = 1'b0;
      dp_seen_nxt      = 1'b0;
    end else begin
      unique case (mode_r)
        ctt_pkg::MODE_ENTITY: begin
          has_a = 1'b1;
          if (is_letter(c) || is_digit(c) || c == ctt_pkg::CH_DOT || c == ctt_pkg::CH_UNDER) begin
            slot_a = mk(1'b0, ctt_pkg::KIND_ENTITY, c);
          end else begin
            slot_a  = mk(1'b1, ctt_pkg::KIND_ENTITY, 8'h00);
            restart = 1'b1;
          end
        end
        ctt_pkg::MODE_NUMBER: begin
          if (is_digit(c) || c == ctt_pkg::CH_UNDER || (c == ctt_pkg::CH_DOT && !dp_seen_r)) begin
            if (c == ctt_pkg::CH_DOT) begin
              dp_seen_nxt = 1'b1;
            end
            has_a  = c != ctt_pkg::CH_UNDER;
            slot_a = mk(1'b0, ctt_pkg::KIND_NUMBER, c);
          end else begin
            has_a   = 1'b1;
            slot_a  = mk(1'b1, ctt_pkg::KIND_NUMBER, 8'h00);
            restart = 1'b1;
          end
        end
        ctt_pkg::MODE_STRING: begin
          if (c == (quote_single_r ? ctt_pkg::CH_SQUOTE : ctt_pkg::CH_DQUOTE)) begin
            mode_nxt = ctt_pkg::MODE_AFTER;
          end else if (c == ctt_pkg::CH_BSLASH) begin
            mode_nxt = ctt_pkg::MODE_ESCAPE;
          end else begin
            has_a  = 1'b1;
            slot_a = mk(1'b0, ctt_pkg::KIND_STRING, c);
          end
        end
        ctt_pkg::MODE_ESCAPE: begin
          has_a    = 1'b1;
          slot_a   = mk(1'b0, ctt_pkg::KIND_STRING,
                        (c == ctt_pkg::CH_LOW_N) ? ctt_pkg::CH_LF : c);
          mode_nxt = ctt_pkg::MODE_STRING;
        end
        ctt_pkg::MODE_AFTER: begin
          if (c == ctt_pkg::CH_COLON) begin
            has_a    = 1'b1;
            slot_a   = mk(1'b1, ctt_pkg::KIND_LABEL, 8'h00);
            mode_nxt = ctt_pkg::MODE_IDLE;
          end else if (!is_space(c)) begin
            has_a   = 1'b1;
            slot_a  = mk(1'b1, ctt_pkg::KIND_STRING, 8'h00);
            restart = 1'b1;
          end
        end
        ctt_pkg::MODE_PLUS: begin
          has_a = 1'b1;
          if (c == ctt_pkg::CH_EQUAL) begin
            slot_a   = mk(1'b1, ctt_pkg::KIND_APPEND, 8'h00);
            mode_nxt = ctt_pkg::MODE_IDLE;
          end else begin
            slot_a  = mk(1'b1, ctt_pkg::KIND_UNKNOWN, 8'h00);
            restart = 1'b1;
          end
        end
        ctt_pkg::MODE_COMMENT: begin
          if (c == ctt_pkg::CH_LF) begin
            mode_nxt = ctt_pkg::MODE_IDLE;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        mode_nxt = ctt_pkg::MODE_IDLE;
        has_n    = 1'b1;
        priority if (is_space(c)) begin
          has_n = 1'b0;
        end else if (is_letter(c)) begin
          mode_nxt = ctt_pkg::MODE_ENTITY;
          nr       = mk(1'b0, ctt_pkg::KIND_ENTITY, c);
        end else if (is_digit(c)) begin
          mode_nxt    = ctt_pkg::MODE_NUMBER;
          dp_seen_nxt = 1'b0;
          nr          = mk(1'b0, ctt_pkg::KIND_NUMBER, c);
        end else if (c == ctt_pkg::CH_EQUAL) begin
          nr = mk(1'b1, ctt_pkg::KIND_ASSIGN, 8'h00);
        end else if (c == ctt_pkg::CH_PLUS) begin
          mode_nxt = ctt_pkg::MODE_PLUS;
          has_n    = 1'b0;
        end else if (c == ctt_pkg::CH_DQUOTE || c == ctt_pkg::CH_SQUOTE) begin
          mode_nxt         = ctt_pkg::MODE_STRING;
          quote_single_nxt = c == ctt_pkg::CH_SQUOTE;
          has_n            = 1'b0;
        end else if (c == ctt_pkg::CH_SEMI) begin
          nr = mk(1'b1, ctt_pkg::KIND_TERM, 8'h00);
        end else if (c == ctt_pkg::CH_COLON || c == ctt_pkg::CH_COMMA) begin
          nr = mk(1'b1, ctt_pkg::KIND_DELIM, 8'h00);
        end else if (c == ctt_pkg::CH_LPAREN) begin
          nr = mk(1'b1, ctt_pkg::KIND_OPEN, 8'h00);
        end else if (c == ctt_pkg::CH_RPAREN) begin
          nr = mk(1'b1, ctt_pkg::KIND_CLOSE, 8'h00);
        end else if (c == ctt_pkg::CH_HASH) begin
          mode_nxt = ctt_pkg::MODE_COMMENT;
          has_n    = 1'b0;
        end else begin
          nr = mk(1'b1, ctt_pkg::KIND_UNKNOWN, 8'h00);
        end

        if (has_n) begin
          if (has_a) begin
            slot_b = nr;
            has_b  = 1'b1;
          end else begin
            slot_a = nr;
            has_a  = 1'b1;
          end
        end
      end
    end

    // Mark the final result of this request.
    if (has_b) begin
      slot_b.last_of_item = 1'b1;
      slot_b.stream_done  = in_chan.end_of_text;
    end else begin
      slot_a.last_of_item = 1'b1;
      slot_a.stream_done  = in_chan.end_of_text;
    end
    res0    = slot_a;
    res1    = slot_b;
    res_cnt = {has_b, has_a & ~has_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= ctt_pkg::MODE_IDLE;
      quote_single_r <= 1'b0;
      dp_seen_r      <= 1'b0;
    end else if (accept) begin
      mode_r         <= mode_nxt;
      quote_single_r <= quote_single_nxt;
      dp_seen_r      <= dp_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_cnt != 2'd0) begin
      fifo_r[tail_r] <= res0;
    end
    if (accept && res_cnt == 2'd2) begin
      fifo_r[tail_r + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (accept) begin
        tail_r <= tail_r + PtrW'(res_cnt);
      end
      if (pop) begin
        head_r <= head_r + PtrW'(1);
      end
      count_r <= count_r + (accept ? CntW'(res_cnt) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  assign in_chan.ready = count_r <= CntW'(FifoDepth - 2);

  assign out_chan.valid        = count_r != '0;
  assign out_chan.is_token_end = fifo_r[head_r].is_token_end;
  assign out_chan.token_kind   = fifo_r[head_r].token_kind;
  assign out_chan.data_char    = fifo_r[head_r].data_char;
  assign out_chan.stream_done  = fifo_r[head_r].stream_done;
  assign out_chan.last_of_item = fifo_r[head_r].last_of_item;

endmodule

// ----- design/ctt_checker.sv -----
module ctt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_is_token_end,
  input logic [3:0] out_token_kind,
  input logic [7:0] out_data_char,
  input logic       out_stream_done,
  input logic       out_last_of_item
);

  // The end of the stream is always the last result of its request.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_last_of_item)
    else $error("stream_done without last_of_item");

  // Token ends carry no character.
  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_token_end |-> out_data_char == 8'h00)
    else $error("token end with nonzero data_char");

  // Only entities, numbers and strings carry characters.
  a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_token_end |->
      out_token_kind == ctt_pkg::KIND_ENTITY || out_token_kind == ctt_pkg::KIND_NUMBER ||
      out_token_kind == ctt_pkg::KIND_STRING)
    else $error("data character in a token that has no characters");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= ctt_pkg::KIND_CLOSE)
    else $error("token_kind out of range");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_is_token_end (out_chan.is_token_end),
  .out_token_kind   (out_chan.token_kind),
  .out_data_char    (out_chan.data_char),
  .out_stream_done  (out_chan.stream_done),
  .out_last_of_item (out_chan.last_of_item)
);

// ----- tb/sv/ctt_checker.sv -----
`timescale 1ns / 100ps

module ctt_result_checker (
  input  logic clk,
  input  logic rst_n,
  ctt_in_if    in_mon,
  ctt_out_if   out_mon,
  output int   mismatch_count,
  output int   pending_count,
  output int   compared_count
);

  ctt_pkg::mode_t   lex_mode;
  logic             quote_single;
  logic             point_seen;
  ctt_pkg::result_t item_results[$];
  ctt_pkg::result_t expected_tokens[$];

  initial begin
    lex_mode     = ctt_pkg::MODE_IDLE;
    quote_single = 1'b0;
    point_seen   = 1'b0;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == ctt_pkg::CH_SPACE || c == ctt_pkg::CH_TAB ||
           c == ctt_pkg::CH_CR || c == ctt_pkg::CH_LF;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_result(logic tok_end, logic [3:0] kind, logic [7:0] ch);
    ctt_pkg::result_t r;
    r = '0;
    r.is_token_end = tok_end;
    r.token_kind   = kind;
    r.data_char    = tok_end ? 8'h00 : ch;
    item_results.push_back(r);
  endfunction

  // Lexes a byte with no token open.
  function automatic void open_token(logic [7:0] c);
    lex_mode = ctt_pkg::MODE_IDLE;
    if (is_blank(c)) return;
    if (is_alpha(c)) begin
      lex_mode = ctt_pkg::MODE_ENTITY;
      add_result(1'b0, ctt_pkg::KIND_ENTITY, c);
    end else if (is_num(c)) begin
      lex_mode   = ctt_pkg::MODE_NUMBER;
      point_seen = 1'b0;
      add_result(1'b0, ctt_pkg::KIND_NUMBER, c);
    end else begin
      case (c)
        ctt_pkg::CH_EQUAL: add_result(1'b1, ctt_pkg::KIND_ASSIGN, 8'h00);
        ctt_pkg::CH_PLUS: lex_mode = ctt_pkg::MODE_PLUS;
        ctt_pkg::CH_DQUOTE: begin
          lex_mode     = ctt_pkg::MODE_STRING;
          quote_single = 1'b0;
        end
        ctt_pkg::CH_SQUOTE: begin
          lex_mode     = ctt_pkg::MODE_STRING;
          quote_single = 1'b1;
        end
        ctt_pkg::CH_SEMI: add_result(1'b1, ctt_pkg::KIND_TERM, 8'h00);
        ctt_pkg::CH_COLON, ctt_pkg::CH_COMMA: add_result(1'b1, ctt_pkg::KIND_DELIM, 8'h00);
        ctt_pkg::CH_LPAREN: add_result(1'b1, ctt_pkg::KIND_OPEN, 8'h00);
        ctt_pkg::CH_RPAREN: add_result(1'b1, ctt_pkg::KIND_CLOSE, 8'h00);
        ctt_pkg::CH_HASH: lex_mode = ctt_pkg::MODE_COMMENT;
        default: add_result(1'b1, ctt_pkg::KIND_UNKNOWN, 8'h00);
      endcase
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [7:0] closing;
    closing = quote_single ? ctt_pkg::CH_SQUOTE : ctt_pkg::CH_DQUOTE;
    case (lex_mode)
      ctt_pkg::MODE_ENTITY: begin
        if (is_alpha(c) || is_num(c) || c == ctt_pkg::CH_DOT || c == ctt_pkg::CH_UNDER) begin
          add_result(1'b0, ctt_pkg::KIND_ENTITY, c);
        end else begin
          add_result(1'b1, ctt_pkg::KIND_ENTITY, 8'h00);
          open_token(c);
        end
      end
      ctt_pkg::MODE_NUMBER: begin
        if (is_num(c) || c == ctt_pkg::CH_UNDER || (c == ctt_pkg::CH_DOT && !point_seen)) begin
          if (c == ctt_pkg::CH_DOT) point_seen = 1'b1;
          // Digit separators are swallowed.
          if (c != ctt_pkg::CH_UNDER) add_result(1'b0, ctt_pkg::KIND_NUMBER, c);
        end else begin
          add_result(1'b1, ctt_pkg::KIND_NUMBER, 8'h00);
          open_token(c);
        end
      end
      ctt_pkg::MODE_STRING: begin
        if (c == closing) lex_mode = ctt_pkg::MODE_AFTER;
        else if (c == ctt_pkg::CH_BSLASH) lex_mode = ctt_pkg::MODE_ESCAPE;
        else add_result(1'b0, ctt_pkg::KIND_STRING, c);
      end
      ctt_pkg::MODE_ESCAPE: begin
        add_result(1'b0, ctt_pkg::KIND_STRING, (c == ctt_pkg::CH_LOW_N) ? ctt_pkg::CH_LF : c);
        lex_mode = ctt_pkg::MODE_STRING;
      end
      ctt_pkg::MODE_AFTER: begin
        // A closed string waits for the next non-blank byte to learn if it is a label.
        if (!is_blank(c)) begin
          if (c == ctt_pkg::CH_COLON) begin
            add_result(1'b1, ctt_pkg::KIND_LABEL, 8'h00);
            lex_mode = ctt_pkg::MODE_IDLE;
          end else begin
            add_result(1'b1, ctt_pkg::KIND_STRING, 8'h00);
            open_token(c);
          end
        end
      end
      ctt_pkg::MODE_PLUS: begin
        if (c == ctt_pkg::CH_EQUAL) begin
          add_result(1'b1, ctt_pkg::KIND_APPEND, 8'h00);
          lex_mode = ctt_pkg::MODE_IDLE;
        end else begin
          add_result(1'b1, ctt_pkg::KIND_UNKNOWN, 8'h00);
          open_token(c);
        end
      end
      ctt_pkg::MODE_COMMENT: begin
        if (c == ctt_pkg::CH_LF) lex_mode = ctt_pkg::MODE_IDLE;
      end
      default: open_token(c);
    endcase
  endfunction

  function automatic void tokenize_request(logic [7:0] c, logic eot);
    ctt_pkg::result_t tail;
    item_results.delete();
    if (eot) begin
      case (lex_mode)
        ctt_pkg::MODE_ENTITY: add_result(1'b1, ctt_pkg::KIND_ENTITY, 8'h00);
        ctt_pkg::MODE_NUMBER: add_result(1'b1, ctt_pkg::KIND_NUMBER, 8'h00);
        ctt_pkg::MODE_STRING, ctt_pkg::MODE_ESCAPE, ctt_pkg::MODE_AFTER:
          add_result(1'b1, ctt_pkg::KIND_STRING, 8'h00);
        ctt_pkg::MODE_PLUS: add_result(1'b1, ctt_pkg::KIND_UNKNOWN, 8'h00);
        default: ;
      endcase
      lex_mode     = ctt_pkg::MODE_IDLE;
      quote_single = 1'b0;
      point_seen   = 1'b0;
    end else begin
      lex_char(c);
    end
    if (item_results.size() > 0) begin
      tail = item_results.pop_back();
      tail.last_of_item = 1'b1;
      tail.stream_done  = eot;
      item_results.push_back(tail);
    end
    foreach (item_results[i]) expected_tokens.push_back(item_results[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got %h, expected %h",
                                compared_count, name, got, want));
    end
  endtask

  task automatic compare_result(input ctt_pkg::result_t got);
    ctt_pkg::result_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: end=%b kind=%0d char=%h",
                                got.is_token_end, got.token_kind, got.data_char));
      return;
    end
    want = expected_tokens.pop_front();
    check_field("is_token_end", 8'(got.is_token_end), 8'(want.is_token_end));
    check_field("token_kind", 8'(got.token_kind), 8'(want.token_kind));
    check_field("data_char", got.data_char, want.data_char);
    check_field("stream_done", 8'(got.stream_done), 8'(want.stream_done));
    check_field("last_of_item", 8'(got.last_of_item), 8'(want.last_of_item));
    compared_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        compare_result({out_mon.is_token_end, out_mon.token_kind, out_mon.data_char,
                        out_mon.stream_done, out_mon.last_of_item});
      end
      if (in_mon.valid && in_mon.ready) begin
        tokenize_request(in_mon.char_in, in_mon.end_of_text);
      end
    end
    pending_count <= expected_tokens.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int RX_FREE = 0;
  localparam int RX_BUSY = 1;
  localparam int RX_SLOW = 2;
  localparam int RX_HOLD = 3;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;
  int   compared_count;
  int   burst_left;
  int   requests_sent;
  int   counted_requests;
  int   end_marks_sent;

  ctt_in_if  in_ch();
  ctt_out_if out_ch();

  config_text_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  ctt_result_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .compared_count (compared_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_count);
    $display("end of test: mismatches");
    $finish;
  end

  // Sender works in bursts; between bursts it often lowers valid for a random gap.
  task automatic offer_request(input logic [7:0] c, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_in     <= c;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    requests_sent++;
    if (eot) end_marks_sent++;
    counted_requests++;
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_request(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0: return ctt_pkg::CH_SPACE;
      1: return ctt_pkg::CH_TAB;
      2: return ctt_pkg::CH_CR;
      default: return ctt_pkg::CH_LF;
    endcase
  endfunction

  task automatic offer_random_token();
    int         pick;
    int         len;
    int         r;
    logic [7:0] quote;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      offer_request(random_letter(), 1'b0);
      len = $urandom_range(0, 6);
      repeat (len) begin
        r = $urandom_range(0, 9);
        offer_request((r < 5) ? random_letter() : (r < 8) ? random_digit() :
                      (r == 8) ? ctt_pkg::CH_DOT : ctt_pkg::CH_UNDER, 1'b0);
      end
    end else if (pick < 35) begin
      offer_request(random_digit(), 1'b0);
      len = $urandom_range(0, 6);
      repeat (len) begin
        r = $urandom_range(0, 19);
        offer_request((r < 12) ? random_digit() : (r < 15) ? ctt_pkg::CH_UNDER :
                      ctt_pkg::CH_DOT, 1'b0);
      end
    end else if (pick < 50) begin
      quote = $urandom_range(0, 1) ? ctt_pkg::CH_SQUOTE : ctt_pkg::CH_DQUOTE;
      offer_request(quote, 1'b0);
      len = $urandom_range(0, 6);
      repeat (len) begin
        r = $urandom_range(0, 19);
        if (r < 3) begin
          offer_request(ctt_pkg::CH_BSLASH, 1'b0);
          offer_request($urandom_range(0, 1) ? ctt_pkg::CH_LOW_N : random_byte(), 1'b0);
        end else if (r < 6) begin
          offer_request(random_byte(), 1'b0);
        end else begin
          offer_request(8'($urandom_range(32, 126)), 1'b0);
        end
      end
      // Mostly closed strings, some of them turned into labels.
      if ($urandom_range(0, 9) != 0) begin
        offer_request(quote, 1'b0);
        len = $urandom_range(0, 2);
        repeat (len) offer_request(random_blank(), 1'b0);
        if ($urandom_range(0, 9) < 4) offer_request(ctt_pkg::CH_COLON, 1'b0);
      end
    end else if (pick < 58) begin
      offer_request(ctt_pkg::CH_PLUS, 1'b0);
      if ($urandom_range(0, 9) < 7) offer_request(ctt_pkg::CH_EQUAL, 1'b0);
    end else if (pick < 75) begin
      case ($urandom_range(0, 5))
        0: offer_request(ctt_pkg::CH_EQUAL, 1'b0);
        1: offer_request(ctt_pkg::CH_SEMI, 1'b0);
        2: offer_request(ctt_pkg::CH_COLON, 1'b0);
        3: offer_request(ctt_pkg::CH_COMMA, 1'b0);
        4: offer_request(ctt_pkg::CH_LPAREN, 1'b0);
        default: offer_request(ctt_pkg::CH_RPAREN, 1'b0);
      endcase
    end else if (pick < 80) begin
      offer_request(ctt_pkg::CH_HASH, 1'b0);
      len = $urandom_range(0, 5);
      repeat (len) offer_request(8'($urandom_range(32, 126)), 1'b0);
      offer_request(ctt_pkg::CH_LF, 1'b0);
    end else if (pick < 85) begin
      offer_request(random_byte(), 1'b1);
    end else if (pick < 93) begin
      len = $urandom_range(1, 3);
      repeat (len) offer_request(random_blank(), 1'b0);
    end else begin
      offer_request(random_byte(), 1'b0);
    end
    if ($urandom_range(0, 1) == 0) offer_request(random_blank(), 1'b0);
  endtask

  // Receiver stall pattern; one long hold-off fills the block while the sender keeps going.
  initial begin : receiver
    int   mode;
    int   mode_left;
    int   cycle_no;
    int   r;
    logic held_long;
    out_ch.ready <= 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    cycle_no  = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (mode_left == 0) begin
        if (!held_long && cycle_no > 400) begin
          mode      = RX_HOLD;
          mode_left = 150;
          held_long = 1'b1;
        end else begin
          r         = $urandom_range(0, 19);
          mode      = (r < 8) ? RX_FREE : (r < 14) ? RX_BUSY : (r < 19) ? RX_SLOW : RX_HOLD;
          mode_left = (mode == RX_HOLD) ? $urandom_range(40, 100) : $urandom_range(10, 60);
        end
      end
      mode_left--;
      case (mode)
        RX_FREE: out_ch.ready <= 1'b1;
        RX_BUSY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= 1'b0;
      endcase
    end
  end

  initial begin : sender
    logic mid_drain_done;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.char_in     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    burst_left        = 0;
    requests_sent     = 0;
    counted_requests  = 0;
    end_marks_sent    = 0;
    mid_drain_done    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every token kind, escapes, label, lone plus, second point,
    // unknown high byte, comment, and end of text after a plus, in a string and while idle.
    offer_text("k.=9_..+='\\n' :\"x\";+(),");
    offer_request(8'hFF, 1'b0);
    offer_request(ctt_pkg::CH_HASH, 1'b0);
    offer_request(ctt_pkg::CH_LF, 1'b0);
    offer_request(ctt_pkg::CH_PLUS, 1'b0);
    offer_request(8'h00, 1'b1);
    offer_request(ctt_pkg::CH_DQUOTE, 1'b0);
    offer_request(8'h00, 1'b1);
    offer_request(8'hFF, 1'b1);
    offer_request(8'h00, 1'b0);
    in_ch.valid <= 1'b0;
    wait_drained();

    counted_requests = 0;
    while (counted_requests < 600) begin
      offer_random_token();
      if (!mid_drain_done && counted_requests >= 300) begin
        mid_drain_done = 1'b1;
        in_ch.valid <= 1'b0;
        wait_drained();
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests (%0d end-of-text markers), %0d results compared,",
             requests_sent, end_marks_sent, compared_count);
    $display("with bursty input, output stalls, one long hold-off and a full drain pause.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
